### rtl/hdsb_pkg.sv
// shared types, codes and defaults for the half-duplex serial buffer controller
`timescale 1ns / 1ps

package hdsb_pkg;

    // default sizing
    localparam int FIFO_DEPTH_DEF = 1024;
    localparam int DUMP_SPAN_DEF  = 5;

    // input function codes
    localparam logic [2:0] FUNC_READ  = 3'd0;
    localparam logic [2:0] FUNC_PUT1  = 3'd1;
    localparam logic [2:0] FUNC_PUT2  = 3'd2;
    localparam logic [2:0] FUNC_LINE  = 3'd3;
    localparam logic [2:0] FUNC_TXRDY = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_ACK     = 3'd0;
    localparam logic [2:0] KIND_READ    = 3'd1;
    localparam logic [2:0] KIND_BUSY    = 3'd2;
    localparam logic [2:0] KIND_TX      = 3'd3;
    localparam logic [2:0] KIND_TXREPLY = 3'd4;

    // configuration register indexes and reset values
    localparam logic       CFG_MULTI_BASE  = 1'b0;
    localparam logic       CFG_SINGLE_BASE = 1'b1;
    localparam logic [7:0] MULTI_BASE_RST  = 8'd128;
    localparam logic [7:0] SINGLE_BASE_RST = 8'd192;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic put2;
        logic txchk;
        logic fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_put2;
        logic oq_room;
    } t_sts;

endpackage

### rtl/hdsb_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module hdsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hdsb_ctrl.sv
// sequencing state machine: one item through direct action, dispatch and commit
`timescale 1ns / 1ps

module hdsb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  hdsb_pkg::t_sts i_sts,
    output hdsb_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PUT2,
        S_TXCHK,
        S_FINAL
    } t_state;

    t_state r_state;
    logic   w_ready;
    logic   w_load;

    assign w_ready    = (r_state == S_IDLE) && i_sts.oq_room;
    assign w_load     = i_in_valid && w_ready;
    assign o_in_stall = !w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_load) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= i_sts.is_put2 ? S_PUT2 : S_TXCHK;
                end
                S_PUT2: begin
                    r_state <= S_TXCHK;
                end
                S_TXCHK: begin
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = w_load;
        o_cmd.exec  = (r_state == S_EXEC);
        o_cmd.put2  = (r_state == S_PUT2);
        o_cmd.txchk = (r_state == S_TXCHK);
        o_cmd.fin   = (r_state == S_FINAL);
    end

endmodule

### rtl/hdsb_dp.sv
// datapath: fifos, flags, dump decode, result slots and output queue
`timescale 1ns / 1ps

module hdsb_dp #(
    parameter int FIFO_DEPTH = hdsb_pkg::FIFO_DEPTH_DEF,
    parameter int DUMP_SPAN  = hdsb_pkg::DUMP_SPAN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hdsb_pkg::t_cmd      i_cmd,
    output hdsb_pkg::t_sts      o_sts,
    input  hdsb_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hdsb_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] i_ptr);
        return (i_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : i_ptr + 1'b1;
    endfunction

    hdsb_pkg::t_in_item r_item;

    logic [AW-1:0] r_tx_head, r_tx_tail, r_rx_head, r_rx_tail;
    logic [CW-1:0] r_tx_cnt, r_rx_cnt;
    logic          r_rw;
    logic          r_txr;
    logic [3:0]    r_be;
    logic [7:0]    r_multi, r_single;

    // per-item result slots
    logic [2:0] r_slot_kind [2];
    logic [7:0] r_slot_data [2];
    logic [1:0] r_n;
    logic       r_rx_pend, r_rx_slot;
    logic       r_tx_pend, r_tx_slot;

    // output queue
    hdsb_pkg::t_out_item r_oq [4];
    logic [1:0]          r_oq_head, r_oq_tail;
    logic [2:0]          r_oq_cnt;
    logic                w_pop;

    logic       tx_we, tx_re, rx_we, rx_re;
    logic [7:0] tx_rdata, rx_rdata;
    logic       tx_go, held_go;
    logic       tx_full, rx_full;

    hdsb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_tail),
        .i_wdata (i_cmd.put2 ? r_item.second_byte : r_item.first_byte),
        .i_re    (tx_re),
        .i_raddr (r_tx_head),
        .o_rdata (tx_rdata)
    );

    hdsb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_tail),
        .i_wdata (r_item.first_byte),
        .i_re    (rx_re),
        .i_raddr (r_rx_head),
        .o_rdata (rx_rdata)
    );

    assign tx_full = (r_tx_cnt == CW'(FIFO_DEPTH));
    assign rx_full = (r_rx_cnt == CW'(FIFO_DEPTH));
    assign tx_go   = r_txr && (r_tx_cnt != '0) && (r_be == 4'd0);
    assign held_go = r_rw && (r_rx_cnt != '0);

    assign tx_we = (i_cmd.exec && ((r_item.func == hdsb_pkg::FUNC_PUT1)
                                || (r_item.func == hdsb_pkg::FUNC_PUT2)))
                || i_cmd.put2;
    assign tx_re = i_cmd.txchk && tx_go;
    assign rx_we = i_cmd.exec && (r_item.func == hdsb_pkg::FUNC_LINE) && (r_be != 4'd0);
    assign rx_re = (i_cmd.exec && (r_item.func == hdsb_pkg::FUNC_READ) && (r_rx_cnt != '0))
                || (i_cmd.txchk && held_go);

    // dump decode of the byte leaving the transmit fifo
    logic [7:0] c_byte;
    logic       in_single, in_multi, is_dump;
    logic [2:0] off;
    logic [8:0] s_hi, m_hi;

    always_comb begin
        c_byte    = tx_rdata;
        s_hi      = {1'b0, r_single} + 9'(DUMP_SPAN);
        m_hi      = {1'b0, r_multi} + 9'(DUMP_SPAN);
        in_single = (c_byte >= r_single) && ({1'b0, c_byte} <= s_hi);
        in_multi  = (c_byte >= r_multi) && ({1'b0, c_byte} <= m_hi);
        off       = in_single ? 3'(c_byte - r_single) : 3'(c_byte - r_multi);
        is_dump   = (in_single || in_multi) && (off != 3'd0);
    end

    // slots as committed, with late ram data folded in
    hdsb_pkg::t_out_item e_item [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            e_item[i].kind = r_slot_kind[i];
            e_item[i].data = r_slot_data[i];
            if (r_tx_pend && (r_tx_slot == 1'(i))) begin
                e_item[i].kind = is_dump ? hdsb_pkg::KIND_TXREPLY : hdsb_pkg::KIND_TX;
                e_item[i].data = c_byte;
            end
            if (r_rx_pend && (r_rx_slot == 1'(i))) begin
                e_item[i].data = rx_rdata;
            end
            e_item[i].last = (2'(i) == (r_n - 2'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
    end

    // fifo pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_tx_cnt  <= '0;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_rx_cnt  <= '0;
        end else begin
            if (tx_we) begin
                r_tx_tail <= f_next(r_tx_tail);
                if (tx_full) begin
                    r_tx_head <= f_next(r_tx_head);
                end else begin
                    r_tx_cnt <= r_tx_cnt + CW'(1);
                end
            end else if (tx_re) begin
                r_tx_head <= f_next(r_tx_head);
                r_tx_cnt  <= r_tx_cnt - CW'(1);
            end
            if (rx_we) begin
                r_rx_tail <= f_next(r_rx_tail);
                if (rx_full) begin
                    r_rx_head <= f_next(r_rx_head);
                end else begin
                    r_rx_cnt <= r_rx_cnt + CW'(1);
                end
            end else if (rx_re) begin
                r_rx_head <= f_next(r_rx_head);
                r_rx_cnt  <= r_rx_cnt - CW'(1);
            end
        end
    end

    // flags, config and result slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rw      <= 1'b0;
            r_txr     <= 1'b1;
            r_be      <= 4'd0;
            r_multi   <= hdsb_pkg::MULTI_BASE_RST;
            r_single  <= hdsb_pkg::SINGLE_BASE_RST;
            r_n       <= 2'd0;
            r_rx_pend <= 1'b0;
            r_rx_slot <= 1'b0;
            r_tx_pend <= 1'b0;
            r_tx_slot <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == hdsb_pkg::CFG_MULTI_BASE) begin
                    r_multi <= i_cfg_data;
                end else begin
                    r_single <= i_cfg_data;
                end
            end

            // late read data lands in its slot
            if (r_rx_pend) begin
                r_slot_data[r_rx_slot] <= rx_rdata;
                r_rx_pend <= 1'b0;
            end

            if (i_cmd.exec) begin
                case (r_item.func)
                    hdsb_pkg::FUNC_READ: begin
                        if (r_rx_cnt != '0) begin
                            r_slot_kind[0] <= hdsb_pkg::KIND_READ;
                            r_rx_pend      <= 1'b1;
                            r_rx_slot      <= 1'b0;
                            r_n            <= 2'd1;
                        end else if (!r_rw) begin
                            r_rw <= 1'b1;
                            r_n  <= 2'd0;
                        end else begin
                            r_slot_kind[0] <= hdsb_pkg::KIND_BUSY;
                            r_slot_data[0] <= 8'd0;
                            r_n            <= 2'd1;
                        end
                    end
                    hdsb_pkg::FUNC_PUT1, hdsb_pkg::FUNC_PUT2: begin
                        r_slot_kind[0] <= hdsb_pkg::KIND_ACK;
                        r_slot_data[0] <= 8'd0;
                        r_n            <= 2'd1;
                    end
                    hdsb_pkg::FUNC_LINE: begin
                        r_n <= 2'd0;
                        if (r_be != 4'd0) begin
                            r_be <= r_be - 4'd1;
                            if (r_be == 4'd1) begin
                                r_txr <= 1'b1;
                            end
                        end
                    end
                    hdsb_pkg::FUNC_TXRDY: begin
                        r_n   <= 2'd0;
                        r_txr <= 1'b1;
                    end
                    default: begin
                        r_n <= 2'd0;
                    end
                endcase
            end

            if (i_cmd.txchk) begin
                if (tx_go) begin
                    r_txr     <= 1'b0;
                    r_tx_pend <= 1'b1;
                    r_tx_slot <= r_n[0];
                end
                if (held_go) begin
                    r_rw           <= 1'b0;
                    r_rx_pend      <= 1'b1;
                    r_rx_slot      <= 1'(r_n + {1'b0, tx_go});
                    r_slot_kind[1'(r_n + {1'b0, tx_go})] <= hdsb_pkg::KIND_READ;
                end
                r_n <= r_n + {1'b0, tx_go} + {1'b0, held_go};
            end

            if (i_cmd.fin) begin
                r_tx_pend <= 1'b0;
                if (r_tx_pend && is_dump) begin
                    r_be <= {off, 1'b0};
                end
            end
        end
    end

    // output queue, two results per item at most
    assign w_pop       = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_oq_cnt != 3'd0);
    assign o_out_item  = r_oq[r_oq_head];

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            for (int i = 0; i < 2; i++) begin
                if (2'(i) < r_n) begin
                    r_oq[r_oq_tail + 2'(i)] <= e_item[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_head <= 2'd0;
            r_oq_tail <= 2'd0;
            r_oq_cnt  <= 3'd0;
        end else begin
            if (i_cmd.fin) begin
                r_oq_tail <= r_oq_tail + r_n;
            end
            if (w_pop) begin
                r_oq_head <= r_oq_head + 2'd1;
            end
            r_oq_cnt <= r_oq_cnt + (i_cmd.fin ? {1'b0, r_n} : 3'd0) - {2'b0, w_pop};
        end
    end

    assign o_sts.is_put2 = (r_item.func == hdsb_pkg::FUNC_PUT2);
    assign o_sts.oq_room = (r_oq_cnt <= 3'd2);

    // a held reader never coexists with receive data once an item is done
    a_held_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (!r_rw || (r_rx_cnt == '0)))
        else $error("held reader left with receive data");

    // transmit and held-reader results never share a slot
    a_slot_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && r_rx_pend && r_tx_pend) |-> (r_rx_slot != r_tx_slot))
        else $error("result slot collision");

    // output queue stays within its four entries
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= 3'd4)
        else $error("output queue overflow");

    // no reply can be awaited while the transmitter is marked ready
    a_be_txr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> !(r_txr && (r_be != 4'd0) && $past(r_tx_pend)))
        else $error("reply expected with transmitter ready");

endmodule

### rtl/half_duplex_serial_buffer_ctrl.sv
// top level of the half-duplex serial link buffer controller
`timescale 1ns / 1ps

// Buffers a half-duplex serial link: a transmit fifo and a receive fifo of
// FIFO_DEPTH bytes each, a single held reader, a transmitter-ready flag and a
// count of reply bytes still expected after a dump command. Each input item
// gives zero, one or two result items, the final one marked by last. After the
// accepting edge an item steps through direct action, transmit and
// held-reader dispatch, and commit (a two-byte put adds a second write
// step), and its results enter the output queue at commit. The sequencer
// then returns to idle before it takes the next item, so only one item is
// in flight at a time. The extra step comes from the registered read of each
// fifo memory and its single write port, which a two-byte put uses twice.
// A new item is taken once the sequencer is back at idle and the
// four-entry output queue has room for two results, so up to two results
// waiting downstream do not hold up the input. The fifo memories are not
// cleared after reset; only written entries are ever read, so there is no
// clearing pass. Configuration writes (dump range bases) must land while
// the block is idle.

module half_duplex_serial_buffer_ctrl #(
    parameter int FIFO_DEPTH = hdsb_pkg::FIFO_DEPTH_DEF,
    parameter int DUMP_SPAN  = hdsb_pkg::DUMP_SPAN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hdsb_pkg::t_in_item  i_in_item,
    // result item channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hdsb_pkg::t_out_item o_out_item,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);

    hdsb_pkg::t_cmd cmd;
    hdsb_pkg::t_sts sts;

    // sequencer: one item at a time through its steps
    hdsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // fifos, flags, dump decode and output queue
    hdsb_dp #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .DUMP_SPAN  (DUMP_SPAN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

### sim/half_duplex_serial_buffer_ctrl_tb.sv
// self-checking testbench for the half-duplex serial buffer controller
`timescale 1ns / 1ps

module half_duplex_serial_buffer_ctrl_tb;

    localparam int FIFO_DEPTH   = hdsb_pkg::FIFO_DEPTH_DEF;
    localparam int DUMP_SPAN    = hdsb_pkg::DUMP_SPAN_DEF;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    // covers the tail of any item still inside the block
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int MIXED_ITEMS  = 70;
    localparam int MIXED_PHASES = 4;
    localparam int FLOOD_PUTS   = 520;
    localparam int FLOOD_LINE   = 1060;
    localparam int FLOOD_READS  = 40;

    // func codes with no direct action of their own in the block
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // dut signals; the inputs are known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    hdsb_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    hdsb_pkg::t_out_item o_out_item;
    logic                i_cfg_we    = 1'b0;
    logic                i_cfg_idx   = hdsb_pkg::CFG_MULTI_BASE;
    logic [7:0]          i_cfg_data  = '0;

    // predictor state: the two fifos, flags and reply countdown
    logic [7:0] tx_bytes[$];
    logic [7:0] rx_bytes[$];
    logic       reader_held = 1'b0;
    logic       line_ready  = 1'b1;
    int         reply_left  = 0;
    logic [7:0] multi_base  = hdsb_pkg::MULTI_BASE_RST;
    logic [7:0] single_base = hdsb_pkg::SINGLE_BASE_RST;

    hdsb_pkg::t_in_item  pending_items[$];
    hdsb_pkg::t_out_item expected_results[$];

    int          errors          = 0;
    int          items_sent      = 0;
    int          results_checked = 0;
    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;
    logic        hold_stall      = 1'b0;
    logic        pressure_go     = 1'b0;
    int unsigned cycle_count     = 0;

    half_duplex_serial_buffer_ctrl u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin : clock_gen
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // full fifo drops its oldest byte to make room
    function automatic void queue_tx_byte(input logic [7:0] v);
        if (tx_bytes.size() >= FIFO_DEPTH) begin
            void'(tx_bytes.pop_front());
        end
        tx_bytes.push_back(v);
    endfunction

    function automatic hdsb_pkg::t_out_item make_result(input logic [2:0] k,
                                                        input logic [7:0] d);
        hdsb_pkg::t_out_item r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        return r;
    endfunction

    // works out the results of one accepted item and updates the shadow state
    function automatic void predict_results(input hdsb_pkg::t_in_item it);
        hdsb_pkg::t_out_item res[2];
        int                  n;
        int                  cv;
        int                  off;
        n = 0;
        case (it.func)
            hdsb_pkg::FUNC_READ: begin
                if (rx_bytes.size() > 0) begin
                    res[n] = make_result(hdsb_pkg::KIND_READ, rx_bytes.pop_front());
                    n++;
                end else if (!reader_held) begin
                    reader_held = 1'b1;
                end else begin
                    res[n] = make_result(hdsb_pkg::KIND_BUSY, 8'h00);
                    n++;
                end
            end
            hdsb_pkg::FUNC_PUT1: begin
                queue_tx_byte(it.first_byte);
                res[n] = make_result(hdsb_pkg::KIND_ACK, 8'h00);
                n++;
            end
            hdsb_pkg::FUNC_PUT2: begin
                queue_tx_byte(it.first_byte);
                queue_tx_byte(it.second_byte);
                res[n] = make_result(hdsb_pkg::KIND_ACK, 8'h00);
                n++;
            end
            hdsb_pkg::FUNC_LINE: begin
                // line bytes nobody asked for are dropped
                if (reply_left > 0) begin
                    reply_left--;
                    if (rx_bytes.size() >= FIFO_DEPTH) begin
                        void'(rx_bytes.pop_front());
                    end
                    rx_bytes.push_back(it.first_byte);
                    if (reply_left == 0) begin
                        line_ready = 1'b1;
                    end
                end
            end
            hdsb_pkg::FUNC_TXRDY: begin
                line_ready = 1'b1;
            end
            default: begin
            end
        endcase

        // transmit stage: single range wins where the two ranges overlap
        if (line_ready && tx_bytes.size() > 0 && reply_left == 0) begin
            cv  = int'(tx_bytes.pop_front());
            off = -1;
            if (cv >= int'(single_base) && cv <= int'(single_base) + DUMP_SPAN) begin
                off = cv - int'(single_base);
            end else if (cv >= int'(multi_base) && cv <= int'(multi_base) + DUMP_SPAN) begin
                off = cv - int'(multi_base);
            end
            // a dump with zero offset goes out as a plain byte
            if (off > 0) begin
                reply_left = (off * 2) & 15;
                res[n] = make_result(hdsb_pkg::KIND_TXREPLY, cv[7:0]);
            end else begin
                res[n] = make_result(hdsb_pkg::KIND_TX, cv[7:0]);
            end
            n++;
            line_ready = 1'b0;
        end

        // held reader is served last
        if (reader_held && rx_bytes.size() > 0) begin
            res[n] = make_result(hdsb_pkg::KIND_READ, rx_bytes.pop_front());
            n++;
            reader_held = 1'b0;
        end

        if (n > 0) begin
            res[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_results.push_back(res[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------

    function automatic hdsb_pkg::t_in_item make_item(input logic [2:0] f,
                                                     input logic [7:0] b1,
                                                     input logic [7:0] b2);
        hdsb_pkg::t_in_item it;
        it.func        = f;
        it.first_byte  = b1;
        it.second_byte = b2;
        return it;
    endfunction

    // a byte at or just past one of the dump bases
    function automatic logic [7:0] dump_byte(input int min_off);
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0) begin
            b = single_base + 8'($urandom_range(min_off, DUMP_SPAN));
        end else begin
            b = multi_base + 8'($urandom_range(min_off, DUMP_SPAN));
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        if ($urandom_range(0, 99) < 35) begin
            b = dump_byte(0);
        end else begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    // weighted mix so dumps get their replies and readers find data
    function automatic hdsb_pkg::t_in_item mixed_item();
        hdsb_pkg::t_in_item it;
        int                 u;
        u              = $urandom_range(0, 99);
        it.first_byte  = pick_byte();
        it.second_byte = pick_byte();
        if (u < 20) begin
            it.func = hdsb_pkg::FUNC_READ;
        end else if (u < 40) begin
            it.func = hdsb_pkg::FUNC_PUT1;
        end else if (u < 55) begin
            it.func = hdsb_pkg::FUNC_PUT2;
        end else if (u < 82) begin
            it.func = hdsb_pkg::FUNC_LINE;
        end else if (u < 96) begin
            it.func = hdsb_pkg::FUNC_TXRDY;
        end else begin
            it.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // driver: offers pending items, predicts each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_items
        logic offer;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_results(i_in_item);
                items_sent++;
            end
            // payload holds while the block stalls
            if (!i_in_valid || !o_in_stall) begin
                offer = pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct;
                if (offer) begin
                    i_in_item <= pending_items.pop_front();
                end
                i_in_valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        hdsb_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, got kind %0d data %02h last %0b",
                         $time, o_out_item.kind, o_out_item.data, o_out_item.last);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_out_item.kind !== want.kind) begin
                    errors++;
                    $display("%0t: kind mismatch, expected %0d actual %0d",
                             $time, want.kind, o_out_item.kind);
                end
                if (o_out_item.data !== want.data) begin
                    errors++;
                    $display("%0t: data mismatch, expected %02h actual %02h",
                             $time, want.data, o_out_item.data);
                end
                if (o_out_item.last !== want.last) begin
                    errors++;
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, want.last, o_out_item.last);
                end
            end
        end
        i_out_stall <= hold_stall || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // long receiver hold-off so the output queue fills and the input stalls
    initial begin : hold_off
        wait (pressure_go);
        @(posedge i_clk);
        hold_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_stall <= 1'b0;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // phase helpers
    // ------------------------------------------------------------------

    // only called while the block is idle
    task automatic set_bases(input logic [7:0] mb, input logic [7:0] sb);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= hdsb_pkg::CFG_MULTI_BASE;
        i_cfg_data <= mb;
        multi_base = mb;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= hdsb_pkg::CFG_SINGLE_BASE;
        i_cfg_data <= sb;
        single_base = sb;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_idle(input t_idle_mode mode);
        send_idle_pct = (mode == IDLE_SEND) ? 52 : (mode == IDLE_BOTH) ? 17 : 0;
        recv_idle_pct = (mode == IDLE_RECV) ? 52 : (mode == IDLE_BOTH) ? 17 : 0;
    endtask

    // all items accepted, all results seen, then let the pipeline empty
    task automatic wait_all_done();
        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] mb;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part from reset state with the default bases
        set_idle(IDLE_NONE);
        set_bases(hdsb_pkg::MULTI_BASE_RST, hdsb_pkg::SINGLE_BASE_RST);
        // reader held, then a second reader refused
        pending_items.push_back(make_item(hdsb_pkg::FUNC_READ, 8'h00, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_READ, 8'hFF, 8'hFF));
        // ack then sent, then one that waits while the line is busy
        pending_items.push_back(make_item(hdsb_pkg::FUNC_PUT1, 8'h00, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_PUT1, 8'hFF, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_TXRDY, 8'h00, 8'h00));
        // both bases with zero offset go out as plain bytes
        pending_items.push_back(make_item(hdsb_pkg::FUNC_PUT2, hdsb_pkg::SINGLE_BASE_RST,
                                          hdsb_pkg::MULTI_BASE_RST));
        // unexpected line byte, dropped
        pending_items.push_back(make_item(hdsb_pkg::FUNC_LINE, 8'hAA, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_TXRDY, 8'h00, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_TXRDY, 8'h00, 8'h00));
        // nothing left to send
        pending_items.push_back(make_item(hdsb_pkg::FUNC_TXRDY, 8'h00, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_PUT1,
                                          hdsb_pkg::SINGLE_BASE_RST + 8'd1, 8'h00));
        // first reply byte feeds the held reader, second completes the reply
        pending_items.push_back(make_item(hdsb_pkg::FUNC_LINE, 8'h00, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_LINE, 8'hFF, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_READ, 8'h00, 8'h00));
        pending_items.push_back(make_item(FUNC_UNUSED_LO, 8'h00, 8'h00));
        pending_items.push_back(make_item(FUNC_UNUSED_HI, 8'hFF, 8'hFF));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_PUT2,
                                          hdsb_pkg::MULTI_BASE_RST + 8'd1, 8'h7F));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_LINE, 8'h5A, 8'h00));
        // second reply byte releases 8'h7F
        pending_items.push_back(make_item(hdsb_pkg::FUNC_LINE, 8'hA5, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_READ, 8'h00, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_READ, 8'h00, 8'h00));
        // held again, then refused
        pending_items.push_back(make_item(hdsb_pkg::FUNC_READ, 8'h00, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_READ, 8'h00, 8'h00));
        pending_items.push_back(make_item(hdsb_pkg::FUNC_PUT1,
                                          hdsb_pkg::MULTI_BASE_RST + 8'd5, 8'h00));
        wait_all_done();

        // mixed random phases, one base setting and one idle pattern each
        for (int p = 0; p < MIXED_PHASES; p++) begin
            case (p)
                0: set_bases(8'd0, 8'd255);
                1: set_bases(8'd255, 8'd0);
                2: set_bases(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: begin
                    // overlapping ranges, single range takes priority
                    mb = 8'($urandom_range(0, 250));
                    set_bases(mb, mb + 8'd2);
                end
            endcase
            set_idle(t_idle_mode'(p));
            if (p == 0) begin
                pressure_go = 1'b1;
            end
            for (int i = 0; i < MIXED_ITEMS; i++) begin
                pending_items.push_back(mixed_item());
            end
            wait_all_done();
        end

        // flood: stack up dumps past a full tx fifo, then answer many of them so
        // the rx fifo overflows too, then read some back
        set_bases(hdsb_pkg::MULTI_BASE_RST, hdsb_pkg::SINGLE_BASE_RST);
        set_idle(IDLE_RECV);
        for (int i = 0; i < FLOOD_PUTS; i++) begin
            pending_items.push_back(make_item(hdsb_pkg::FUNC_PUT2, dump_byte(1),
                                              dump_byte(1)));
        end
        for (int i = 0; i < FLOOD_LINE; i++) begin
            pending_items.push_back(make_item(hdsb_pkg::FUNC_LINE,
                                              8'($urandom_range(0, 255)),
                                              8'($urandom_range(0, 255))));
        end
        for (int i = 0; i < FLOOD_READS; i++) begin
            pending_items.push_back(make_item(hdsb_pkg::FUNC_READ,
                                              8'($urandom_range(0, 255)),
                                              8'($urandom_range(0, 255))));
        end
        wait_all_done();

        $display("run covered %0d input items and %0d checked result items", items_sent,
                 results_checked);
        $display("phases: directed, four mixed with varied bases and idling, fifo overflow");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
